@@ src/fdmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmf_pkg: shared types and constants of the duplicate message filter
// Request and result structs, command codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fdmf_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 128;
  localparam int INDEX_W = 64;
  localparam int LEN_W   = 32;
  localparam int KEY_W   = INDEX_W + LEN_W;

  // Request command codes.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  typedef struct packed {
    logic                      command;
    logic signed [INDEX_W-1:0] send_index;
    logic        [LEN_W-1:0]   msg_len;
  } in_t;

  typedef struct packed {
    logic duplicate;
    logic added;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture a new request and start a search
    logic rd;      // read the next stored entry
    logic commit;  // write the result and update the table
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;     // table holds no entries
    logic last;      // current read is the last valid entry
    logic out_free;  // result register can take a new result
  } stat_t;

endpackage

@@ src/fifo_duplicate_message_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_duplicate_message_filter_top: duplicate message filter
// Remembers the most recent message keys (send index and length) in a table
// with first-in-first-out replacement and flags repeated messages.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on in_data when in_valid is high and in_stall is low.
//   An add request (command CMD_ADD) stores the key unless an equal key is
//   already in the table; a full table drops its oldest key first. A find
//   request (command CMD_FIND) only reports whether the key is present.
//   Each request yields exactly one result on out_data: duplicate is set when
//   an equal key was found, added when this request stored its key.
//   The search reads one stored entry per cycle from a single-port memory,
//   scanning every valid entry oldest first, then drains the read pipe and
//   commits; an empty table skips the scan and the drain. The result is
//   visible in the cycle after the commit.
//   The result sits in an output register, so the next request is accepted
//   while an earlier result still waits. If out_stall holds the register
//   when a new result is ready, the block waits in its commit step and keeps
//   in_stall high until the register frees up.
//   Reset empties the table at once by clearing the fill count and the
//   oldest pointer; the key memory itself is not cleared and needs no pass.
// ----------------------------------------------------------------------------
module fifo_duplicate_message_filter_top #(
  parameter int TABLE_ENTRIES = fdmf_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  fdmf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output fdmf_pkg::out_t out_data
);

  fdmf_pkg::cmd_t  cmd;
  fdmf_pkg::stat_t stat;
  logic            busy;

  // The controller sequences one request at a time through the datapath.
  fdmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // The datapath owns the key table and the result register.
  fdmf_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Requests are taken only while the sequencer is idle.
  assign in_stall = busy;

  // After a request is taken, the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still in progress");

  // A result appears only through a commit of a request.
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result shown without a commit");

  // The table is never scanned while it is empty.
  a_no_scan_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> !stat.empty)
    else $error("scan issued on an empty table");

  // A duplicate is never also stored.
  a_dup_not_added: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.duplicate && out_data.added))
    else $error("result reports both duplicate and added");

endmodule

@@ src/fdmf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmf_ctrl: request sequencer
// Steps one request through search, drain of the read pipe and commit.
// ----------------------------------------------------------------------------
module fdmf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  fdmf_pkg::stat_t stat,
  output fdmf_pkg::cmd_t  cmd,
  output logic            busy
);

  fdmf_pkg::state_t state_r;
  fdmf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdmf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.empty ? fdmf_pkg::ST_FINISH : fdmf_pkg::ST_SCAN;
        end
      end
      fdmf_pkg::ST_SCAN: begin
        if (stat.last) begin
          state_nxt = fdmf_pkg::ST_DRAIN;
        end
      end
      fdmf_pkg::ST_DRAIN: begin
        state_nxt = fdmf_pkg::ST_FINISH;
      end
      fdmf_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          state_nxt = fdmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fdmf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      fdmf_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = in_valid;
      end
      fdmf_pkg::ST_SCAN: begin
        cmd.rd = 1'b1;
      end
      fdmf_pkg::ST_DRAIN: begin
        cmd = '0;
      end
      fdmf_pkg::ST_FINISH: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/fdmf_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmf_dpath: key table and search datapath
// Holds the key memory, fill count, oldest pointer, scan index, match flag
// and the result register.
// ----------------------------------------------------------------------------
module fdmf_dpath #(
  parameter int TABLE_ENTRIES = fdmf_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  fdmf_pkg::cmd_t  cmd,
  output fdmf_pkg::stat_t stat,
  input  fdmf_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fdmf_pkg::out_t  out_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int KW = fdmf_pkg::KEY_W;

  localparam logic [AW:0]   ENTRIES_A = (AW + 1)'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] ENTRIES_C = CW'(TABLE_ENTRIES);

  logic [KW-1:0]  mem [TABLE_ENTRIES];

  fdmf_pkg::in_t  key_r;
  logic [KW-1:0]  rd_data_r;
  logic           rd_vld_r;
  logic           hit_r;
  logic [CW-1:0]  idx_r;
  logic [CW-1:0]  count_r;
  logic [AW-1:0]  oldest_r;
  fdmf_pkg::out_t out_r;
  logic           out_valid_r;

  logic [AW:0]    rd_sum;
  logic [AW-1:0]  rd_addr;
  logic [AW:0]    ins_sum;
  logic [AW-1:0]  ins_slot;
  logic [AW-1:0]  oldest_inc;
  logic           full;
  logic           match;
  logic           do_add;
  logic [KW-1:0]  wr_data;

  // Slot of the entry being scanned, oldest first, wrapped around the table.
  assign rd_sum  = {1'b0, oldest_r} + {1'b0, idx_r[AW-1:0]};
  assign rd_addr = (rd_sum >= ENTRIES_A) ? AW'(rd_sum - ENTRIES_A) : rd_sum[AW-1:0];

  assign full       = (count_r == ENTRIES_C);
  assign oldest_inc = (oldest_r == LAST_SLOT) ? '0 : oldest_r + AW'(1);
  assign ins_sum    = {1'b0, oldest_r} + {1'b0, count_r[AW-1:0]};
  assign ins_slot   = full ? oldest_r :
                      (ins_sum >= ENTRIES_A) ? AW'(ins_sum - ENTRIES_A) : ins_sum[AW-1:0];

  assign wr_data = {key_r.send_index, key_r.msg_len};
  assign match   = rd_vld_r && (rd_data_r == wr_data);
  assign do_add  = cmd.commit && (key_r.command == fdmf_pkg::CMD_ADD) && !hit_r;

  assign stat.empty    = (count_r == '0);
  assign stat.last     = (idx_r == count_r - CW'(1));
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (do_add) begin
      mem[ins_slot] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.load) begin
      key_r <= in_data;
    end
    if (cmd.commit) begin
      out_r.duplicate <= hit_r;
      out_r.added     <= do_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      idx_r       <= '0;
      count_r     <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd;

      if (cmd.load) begin
        hit_r <= 1'b0;
        idx_r <= '0;
      end else begin
        if (match) begin
          hit_r <= 1'b1;
        end
        if (cmd.rd) begin
          idx_r <= idx_r + CW'(1);
        end
      end

      if (do_add) begin
        if (full) begin
          oldest_r <= oldest_inc;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end

      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ sim/tb_fifo_duplicate_message_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_duplicate_message_filter_top: self-checking bench for the filter
// Drives add and find requests through the valid/stall input channel. A model
// of the key table in the bench predicts the duplicate and added flags of
// every request; each result is checked in order against the directed verdict
// where one is given, else against the model. The stimulus is a directed table
// followed by random phases with idling and back-pressure.
module tb_fifo_duplicate_message_filter_top;

  localparam int TABLE_ENTRIES   = fdmf_pkg::DEFAULT_TABLE_ENTRIES;
  localparam int REQUESTS_PER_PHASE = 475;  // four phases, about 1900 requests
  localparam int HISTORY_DEPTH   = 300;
  localparam int HOLDOFF_CYCLES  = 600;
  // Slowest request is a full-table scan; with idle gaps and stalls on top,
  // CYCLE_LIMIT leaves a wide margin.
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int MAX_REPORTS     = 10;

  localparam logic [fdmf_pkg::INDEX_W-1:0] INDEX_MIN =
    {1'b1, {(fdmf_pkg::INDEX_W-1){1'b0}}};
  localparam logic [fdmf_pkg::INDEX_W-1:0] INDEX_MAX =
    {1'b0, {(fdmf_pkg::INDEX_W-1){1'b1}}};
  localparam logic [fdmf_pkg::INDEX_W-1:0] INDEX_ONES = '1;
  localparam logic [fdmf_pkg::LEN_W-1:0]   LEN_MAX = '1;

  // Verdicts that can be read straight off the table contents.
  localparam fdmf_pkg::out_t MISS  = '{duplicate: 1'b0, added: 1'b0};
  localparam fdmf_pkg::out_t FRESH = '{duplicate: 1'b0, added: 1'b1};
  localparam fdmf_pkg::out_t HIT   = '{duplicate: 1'b1, added: 1'b0};

  typedef struct packed {
    logic [fdmf_pkg::INDEX_W-1:0] index;
    logic [fdmf_pkg::LEN_W-1:0]   len;
  } msg_key_t;

  typedef struct packed {
    logic           known;    // verdict column holds the expected result
    fdmf_pkg::out_t verdict;
    fdmf_pkg::in_t  req;
  } directed_row_t;

  // Directed requests, starting from an empty table. Rows without a known
  // verdict are checked against the table model; their verdict column is unused.
  directed_row_t directed_rows [19] = '{
    '{1'b1, MISS,  '{fdmf_pkg::CMD_FIND, INDEX_MIN, 32'h0}},   // lookup in an empty table
    '{1'b1, FRESH, '{fdmf_pkg::CMD_ADD,  INDEX_MIN, 32'h0}},   // first add goes to slot 0
    '{1'b1, HIT,   '{fdmf_pkg::CMD_ADD,  INDEX_MIN, 32'h0}},   // repeated add is a duplicate
    '{1'b1, HIT,   '{fdmf_pkg::CMD_FIND, INDEX_MIN, 32'h0}},
    '{1'b1, FRESH, '{fdmf_pkg::CMD_ADD,  INDEX_MAX, LEN_MAX}},
    '{1'b1, MISS,  '{fdmf_pkg::CMD_FIND, INDEX_MAX, 32'h0}},   // same index, other length
    '{1'b1, MISS,  '{fdmf_pkg::CMD_FIND, INDEX_MIN, LEN_MAX}}, // same length, other index
    '{1'b1, FRESH, '{fdmf_pkg::CMD_ADD,  INDEX_ONES, LEN_MAX}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_ADD,  64'h0, 32'h0}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_ADD,  64'h0, 32'h1}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_ADD,  64'h1, 32'h0}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_FIND, 64'h0, 32'h1}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_ADD,  INDEX_MAX, LEN_MAX}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_FIND, INDEX_ONES, LEN_MAX}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_ADD,  64'h5555_5555_5555_5555, 32'hAAAA_AAAA}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_ADD,  64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_FIND, 64'h5555_5555_5555_5555, 32'h5555_5555}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_FIND, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA}},
    '{1'b0, MISS,  '{fdmf_pkg::CMD_ADD,  64'h8000_0000_0000_0001, 32'h8000_0000}}
  };

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  fdmf_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  fdmf_pkg::out_t out_data;

  // Bench copy of the key table.
  logic [fdmf_pkg::INDEX_W-1:0] stored_index [TABLE_ENTRIES];
  logic [fdmf_pkg::LEN_W-1:0]   stored_len   [TABLE_ENTRIES];
  int fill_count  = 0;
  int oldest_slot = 0;

  fdmf_pkg::out_t pending_verdicts [$];  // expected results, oldest first
  msg_key_t       recent_keys [$];       // keys stored lately, some already evicted

  int send_idle_pct    = 0;
  int stall_pct        = 0;
  int holdoff_request  = 0;
  int fail_count       = 0;
  int cycle_count      = 0;

  fifo_duplicate_message_filter_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a run that hangs is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL fifo_duplicate_message_filter_top");
      $finish;
    end
  end

  // Table model: search all valid entries, then store the key on an add that
  // found no match, dropping the oldest entry when the table is full.
  function automatic fdmf_pkg::out_t filter_predict(fdmf_pkg::in_t req);
    fdmf_pkg::out_t v;
    int             slot;
    v = MISS;
    for (int i = 0; i < fill_count; i++) begin
      slot = (oldest_slot + i) % TABLE_ENTRIES;
      if (stored_index[slot] == req.send_index && stored_len[slot] == req.msg_len)
        v.duplicate = 1'b1;
    end
    if (req.command == fdmf_pkg::CMD_ADD && !v.duplicate) begin
      if (fill_count == TABLE_ENTRIES) begin
        slot = oldest_slot;
        oldest_slot = (oldest_slot + 1) % TABLE_ENTRIES;
      end else begin
        slot = (oldest_slot + fill_count) % TABLE_ENTRIES;
        fill_count++;
      end
      stored_index[slot] = req.send_index;
      stored_len[slot]   = req.msg_len;
      v.added = 1'b1;
    end
    return v;
  endfunction

  // Random request mix. Most requests either add a fresh key or reuse a key
  // seen lately, so duplicates, evicted keys and near misses all show up.
  function automatic fdmf_pkg::in_t random_request();
    fdmf_pkg::in_t req;
    msg_key_t      k;
    int            pick;
    int            depth;
    int            offset;
    pick = $urandom_range(99, 0);
    depth = recent_keys.size();
    k.index = {$urandom, $urandom};
    k.len = $urandom_range(1, 0) ? $urandom : $urandom_range(2000, 0);
    req.command = ($urandom_range(99, 0) < 60) ? fdmf_pkg::CMD_ADD : fdmf_pkg::CMD_FIND;
    if (pick < 40) begin
      req.command = fdmf_pkg::CMD_ADD;
    end else if (pick < 80 && depth > 0) begin
      // Half the time pick from the last table's worth of adds, which are
      // most likely still stored.
      if ($urandom_range(1, 0))
        offset = $urandom_range(((depth < TABLE_ENTRIES) ? depth : TABLE_ENTRIES) - 1, 0);
      else
        offset = $urandom_range(depth - 1, 0);
      k = recent_keys[depth - 1 - offset];
      if (pick >= 70)
        k[$urandom_range(fdmf_pkg::KEY_W - 1, 0)] ^= 1'b1;  // near miss
    end else if (pick < 90) begin
      req.command = fdmf_pkg::CMD_FIND;
    end else begin
      case ($urandom_range(3, 0))
        0: k.index = INDEX_MIN;
        1: k.index = INDEX_MAX;
        2: k.index = '0;
        default: k.index = INDEX_ONES;
      endcase
      k.len = $urandom_range(1, 0) ? LEN_MAX : '0;
    end
    req.send_index = k.index;
    req.msg_len    = k.len;
    return req;
  endfunction

  // Offer one request, with random idle cycles first. The request is taken at
  // the edge where in_valid is high and in_stall was low.
  task automatic send_request(input fdmf_pkg::in_t req, input logic known,
                              input fdmf_pkg::out_t verdict);
    fdmf_pkg::out_t predicted;
    msg_key_t       k;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = filter_predict(req);
    pending_verdicts.insert(pending_verdicts.size(), known ? verdict : predicted);
    if (predicted.added) begin
      k.index = req.send_index;
      k.len   = req.msg_len;
      recent_keys.insert(recent_keys.size(), k);
      if (recent_keys.size() > HISTORY_DEPTH) recent_keys.delete(0);
    end
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted result against the oldest expectation,
  // then pick the stall for the next cycle. A hold-off request from the
  // stimulus process keeps the stall high for a long stretch so that the
  // output register fills and the block has to stall its input.
  initial begin : result_checker
    fdmf_pkg::out_t want;
    int             hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: result with nothing expected: duplicate=%0b added=%0b",
                     out_data.duplicate, out_data.added);
        end else begin
          want = pending_verdicts[0];
          pending_verdicts.delete(0);
          if (out_data.duplicate !== want.duplicate || out_data.added !== want.added) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"ERROR: result mismatch: expected duplicate=%0b added=%0b, ",
                        "got duplicate=%0b added=%0b"},
                       want.duplicate, want.added, out_data.duplicate, out_data.added);
          end
        end
      end
      if (holdoff_request > 0) begin
        hold_left = holdoff_request;
        holdoff_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  // Stimulus: reset, the directed table, then the random phases.
  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r])
      send_request(directed_rows[r].req, directed_rows[r].known, directed_rows[r].verdict);
    wait_results_drained();

    // Phases: no idling, sender mostly idle, receiver mostly stalling, and
    // both idling now and then. The first and last phases also get a long
    // receiver hold-off while the sender keeps pushing.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 80; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      if (phase == 0 || phase == 3) holdoff_request = HOLDOFF_CYCLES;
      for (int n = 0; n < REQUESTS_PER_PHASE; n++)
        send_request(random_request(), 1'b0, MISS);
      wait_results_drained();
    end

    // Quiet time afterwards catches any stray result.
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0)
      $display("PASS fifo_duplicate_message_filter_top");
    else
      $display("FAIL fifo_duplicate_message_filter_top");
    $finish;
  end

endmodule
